// ----- hdl/fpalu_pkg.sv -----
// fpalu_pkg: shared types and constants for the q24.8 fixed-point alu
// item structs, operation codes, pipeline control struct
// no dependencies
package fpalu_pkg;

	localparam int FIELD_BITS    = 32;
	localparam int OP_BITS       = 3;
	localparam int FRAC_BITS_DEF = 8;
	localparam int WORD_BITS_DEF = 32;

	typedef enum logic [OP_BITS-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MIN = 3'd4,
		OP_MAX = 3'd5
	} op_t;

	typedef struct packed {
		logic [OP_BITS-1:0]           operation;
		logic signed [FIELD_BITS-1:0] operand_a;
		logic signed [FIELD_BITS-1:0] operand_b;
	} in_item_t;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] result;
		logic                         a_less;
		logic                         a_equal;
		logic                         a_greater;
		logic                         divide_by_zero;
	} out_item_t;

	typedef struct packed {
		logic               valid;
		logic [OP_BITS-1:0] op;
		logic               a_less;
		logic               a_equal;
		logic               a_greater;
		logic               div_zero;
		logic               neg;
	} ctrl_t;

endpackage

// ----- hdl/fpalu_front.sv -----
// fpalu_front: operand decode, compare, add/sub/min/max and multiply
// two pipeline stages feeding the divider cell row
// depends on fpalu_pkg
module fpalu_front import fpalu_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           req_valid,
	input  in_item_t                       req,
	output ctrl_t                          ctrl,
	output logic [WORD_BITS-1:0]           res,
	output logic [WORD_BITS+FRAC_BITS-1:0] quo,
	output logic [WORD_BITS-1:0]           dvs
);

	logic signed [WORD_BITS-1:0]   a_w, b_w;
	logic [WORD_BITS-1:0]          mag_a, mag_b;
	logic [WORD_BITS-1:0]          simple;
	logic [2*WORD_BITS-1:0]        prod;
	logic                          lt, eq, gt;
	ctrl_t                         ctrl_c;

	ctrl_t                         ctrl_s1, ctrl_s2;
	logic [WORD_BITS-1:0]          simple_s1, mag_a_s1, mag_b_s1;
	logic signed [2*WORD_BITS-1:0] prod_s1;
	logic signed [2*WORD_BITS-1:0] prod_sh;
	logic [WORD_BITS-1:0]          res_s2, dvs_s2;
	logic [WORD_BITS+FRAC_BITS-1:0] quo_s2;

	assign a_w = req.operand_a[WORD_BITS-1:0];
	assign b_w = req.operand_b[WORD_BITS-1:0];

	assign lt = a_w < b_w;
	assign eq = a_w == b_w;
	assign gt = a_w > b_w;

	assign mag_a = a_w[WORD_BITS-1] ? (~a_w + 1'b1) : a_w;
	assign mag_b = b_w[WORD_BITS-1] ? (~b_w + 1'b1) : b_w;

	assign prod = (2*WORD_BITS)'(a_w * b_w);

	always_comb begin
		case (req.operation)
			OP_ADD:  simple = a_w + b_w;
			OP_SUB:  simple = a_w - b_w;
			OP_MIN:  simple = lt ? a_w : b_w;
			OP_MAX:  simple = gt ? a_w : b_w;
			default: simple = '0;
		endcase
	end

	always_comb begin
		ctrl_c           = '0;
		ctrl_c.valid     = req_valid;
		ctrl_c.op        = req.operation;
		ctrl_c.a_less    = lt;
		ctrl_c.a_equal   = eq;
		ctrl_c.a_greater = gt;
		ctrl_c.div_zero  = (req.operation == OP_DIV) && (b_w == '0);
		ctrl_c.neg       = a_w[WORD_BITS-1] ^ b_w[WORD_BITS-1];
	end

	assign prod_sh = prod_s1 >>> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else if (en) begin
			ctrl_s1 <= ctrl_c;
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			simple_s1 <= simple;
			prod_s1   <= prod;
			mag_a_s1  <= mag_a;
			mag_b_s1  <= mag_b;
			res_s2    <= (ctrl_s1.op == OP_MUL) ? prod_sh[WORD_BITS-1:0] : simple_s1;
			quo_s2    <= {mag_a_s1, {FRAC_BITS{1'b0}}};
			dvs_s2    <= mag_b_s1;
		end
	end

	assign ctrl = ctrl_s2;
	assign res  = res_s2;
	assign quo  = quo_s2;
	assign dvs  = dvs_s2;

endmodule

// ----- hdl/fpalu_cell.sv -----
// fpalu_cell: one restoring divide step, one quotient bit per cell
// passes control and the non-divide result along unchanged
// depends on fpalu_pkg
module fpalu_cell import fpalu_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  ctrl_t                          ctrl_in,
	input  logic [WORD_BITS-1:0]           res_in,
	input  logic [WORD_BITS+FRAC_BITS-1:0] quo_in,
	input  logic [WORD_BITS-1:0]           rem_in,
	input  logic [WORD_BITS-1:0]           dvs_in,
	output ctrl_t                          ctrl_out,
	output logic [WORD_BITS-1:0]           res_out,
	output logic [WORD_BITS+FRAC_BITS-1:0] quo_out,
	output logic [WORD_BITS-1:0]           rem_out,
	output logic [WORD_BITS-1:0]           dvs_out
);

	localparam int N = WORD_BITS + FRAC_BITS;

	logic [WORD_BITS:0]   trial, diff;
	logic                 ge;
	logic [WORD_BITS-1:0] rem_next;

	ctrl_t                ctrl_q;
	logic [WORD_BITS-1:0] res_q, rem_q, dvs_q;
	logic [N-1:0]         quo_q;

	assign trial    = {rem_in, quo_in[N-1]};
	assign ge       = trial >= {1'b0, dvs_in};
	assign diff     = trial - {1'b0, dvs_in};
	assign rem_next = ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (en) begin
			ctrl_q <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_in;
			quo_q <= {quo_in[N-2:0], ge};
			rem_q <= rem_next;
			dvs_q <= dvs_in;
		end
	end

	assign ctrl_out = ctrl_q;
	assign res_out  = res_q;
	assign quo_out  = quo_q;
	assign rem_out  = rem_q;
	assign dvs_out  = dvs_q;

endmodule

// ----- hdl/fpalu_back.sv -----
// fpalu_back: quotient sign fix, result select, output register and skid stage
// drives the pipeline advance enable
// depends on fpalu_pkg
module fpalu_back import fpalu_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ctrl_t                          ctrl,
	input  logic [WORD_BITS-1:0]           res,
	input  logic [WORD_BITS+FRAC_BITS-1:0] quo,
	output logic                           en,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output out_item_t                      rsp
);

	logic [WORD_BITS-1:0]        q_low, q_signed;
	logic signed [WORD_BITS-1:0] fin;
	out_item_t                   item;
	logic                        push, take;

	out_item_t                   out_q, sk_q;
	logic                        out_valid_q, sk_valid_q;

	assign q_low    = quo[WORD_BITS-1:0];
	assign q_signed = ctrl.neg ? (~q_low + 1'b1) : q_low;

	always_comb begin
		if (ctrl.div_zero) begin
			fin = '0;
		end else if (ctrl.op == OP_DIV) begin
			fin = q_signed;
		end else begin
			fin = res;
		end
	end

	always_comb begin
		item                = '0;
		item.result         = FIELD_BITS'(fin);
		item.a_less         = ctrl.a_less;
		item.a_equal        = ctrl.a_equal;
		item.a_greater      = ctrl.a_greater;
		item.divide_by_zero = ctrl.div_zero;
	end

	assign en   = ~sk_valid_q;
	assign push = en & ctrl.valid;
	assign take = out_valid_q & rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (take || !out_valid_q) begin
			if (sk_valid_q) begin
				out_valid_q <= 1'b1;
				sk_valid_q  <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take || !out_valid_q) begin
			if (sk_valid_q) begin
				out_q <= sk_q;
			end else if (push) begin
				out_q <= item;
			end
		end else if (push) begin
			sk_q <= item;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ----- hdl/fixed_point_q24_8_alu_unit.sv -----
// fixed_point_q24_8_alu_unit: signed fixed-point alu, pipelined, one item per cycle unless the output stalls
// throughput: one item per cycle while the output is not stalled, set by the row of WORD_BITS + FRAC_BITS divide cells
// a two-entry output stage lets items enter while a result waits
// reset clears the control and valid registers only; no clearing pass
// depends on fpalu_pkg, fpalu_front, fpalu_cell, fpalu_back
module fixed_point_q24_8_alu_unit import fpalu_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_item_t rsp
);

	localparam int N = WORD_BITS + FRAC_BITS;

	logic                 en;
	ctrl_t                ctrl_c [N+1];
	logic [WORD_BITS-1:0] res_c  [N+1];
	logic [N-1:0]         quo_c  [N+1];
	logic [WORD_BITS-1:0] rem_c  [N+1];
	logic [WORD_BITS-1:0] dvs_c  [N+1];

	assign req_ready = en;
	assign rem_c[0]  = '0;

	fpalu_front #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.req_valid (req_valid),
		.req       (req),
		.ctrl      (ctrl_c[0]),
		.res       (res_c[0]),
		.quo       (quo_c[0]),
		.dvs       (dvs_c[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		fpalu_cell #(
			.WORD_BITS (WORD_BITS),
			.FRAC_BITS (FRAC_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctrl_in  (ctrl_c[i]),
			.res_in   (res_c[i]),
			.quo_in   (quo_c[i]),
			.rem_in   (rem_c[i]),
			.dvs_in   (dvs_c[i]),
			.ctrl_out (ctrl_c[i+1]),
			.res_out  (res_c[i+1]),
			.quo_out  (quo_c[i+1]),
			.rem_out  (rem_c[i+1]),
			.dvs_out  (dvs_c[i+1])
		);
	end

	fpalu_back #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl_c[N]),
		.res       (res_c[N]),
		.quo       (quo_c[N]),
		.en        (en),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ----- tb/tb_fixed_point_q24_8_alu_unit.sv -----
// tb_fixed_point_q24_8_alu_unit: self-checking bench for the q24.8 fixed-point alu
// directed table then random items under three idle mixes, checked by a local predictor
// depends on fpalu_pkg and fixed_point_q24_8_alu_unit
module tb_fixed_point_q24_8_alu_unit;
	import fpalu_pkg::*;

	localparam logic [OP_BITS-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OP_BITS-1:0] OP_SPARE7 = 3'd7;
	localparam logic [31:0] MOST_NEG = 32'h8000_0000;
	localparam logic [31:0] MOST_POS = 32'h7fff_ffff;
	localparam logic [31:0] ONE_FX   = 32'h0000_0100;
	localparam int RANDOM_PER_PHASE  = 500;
	localparam int HOLD_CYCLES       = 400;
	localparam int DRAIN_CYCLES      = 60;
	localparam int CYCLE_LIMIT       = 200000;
	localparam int PRINT_CAP         = 40;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} table_row_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	in_item_t  req;
	logic      rsp_valid;
	logic      rsp_ready;
	out_item_t rsp;

	out_item_t  pending_answers[$];
	table_row_t directed_rows[$];
	int         send_idle_pct;
	int         recv_idle_pct;
	bit         hold_request;
	int         mismatches;
	int         answers_checked;
	int         items_sent;
	int         zero_divides;
	int         cycle_count;

	fixed_point_q24_8_alu_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic out_item_t alu_answer(in_item_t it);
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic signed [63:0] prod;
		logic [63:0] mag_a;
		logic [63:0] mag_b;
		logic [63:0] quot;
		out_item_t ans;
		a = $signed(it.operand_a);
		b = $signed(it.operand_b);
		ans = '0;
		ans.a_less    = a < b;
		ans.a_equal   = a == b;
		ans.a_greater = a > b;
		case (it.operation)
			OP_ADD: ans.result = 32'(a + b);
			OP_SUB: ans.result = 32'(a - b);
			OP_MUL: begin
				prod = a * b;
				ans.result = 32'(prod >>> FRAC_BITS_DEF);
			end
			OP_DIV: begin
				if (b == 0) begin
					ans.divide_by_zero = 1'b1;
				end else begin
					mag_a = (a < 0) ? -a : a;
					mag_b = (b < 0) ? -b : b;
					quot = (mag_a << FRAC_BITS_DEF) / mag_b;
					if ((a < 0) != (b < 0))
						quot = -quot;
					ans.result = quot[31:0];
				end
			end
			OP_MIN: ans.result = 32'((a < b) ? a : b);
			OP_MAX: ans.result = 32'((a > b) ? a : b);
			default: ans.result = '0;
		endcase
		return ans;
	endfunction

	function automatic logic [31:0] pick_operand();
		logic [31:0] v;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(6))
					0: v = '0;
					1: v = 32'd1;
					2: v = '1;
					3: v = MOST_NEG;
					4: v = MOST_POS;
					5: v = ONE_FX;
					default: v = -ONE_FX;
				endcase
			end
			1, 2: v = $urandom_range(8191) - 4096;
			3: v = $urandom_range(255);
			4: v = $urandom_range(2097151) - 1048576;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		if ($urandom_range(15) < 14)
			it.operation = OP_BITS'($urandom_range(5));
		else
			it.operation = $urandom_range(1) ? OP_SPARE7 : OP_SPARE6;
		it.operand_a = pick_operand();
		it.operand_b = pick_operand();
		if ($urandom_range(9) == 0)
			it.operand_b = it.operand_a;
		if (it.operation == OP_DIV && $urandom_range(9) == 0)
			it.operand_b = '0;
		return it;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch at cycle %0d on %s: got %h, expected %h",
				cycle_count, field, got, want);
	endtask

	task automatic row_pred(logic [OP_BITS-1:0] op, logic [31:0] a, logic [31:0] b);
		table_row_t row;
		row.item.operation = op;
		row.item.operand_a = a;
		row.item.operand_b = b;
		row.typed = 1'b0;
		row.want = '0;
		directed_rows.push_back(row);
	endtask

	task automatic row_known(logic [OP_BITS-1:0] op, logic [31:0] a, logic [31:0] b,
			logic [31:0] res, bit lt, bit eq, bit gt, bit dz);
		table_row_t row;
		row.item.operation = op;
		row.item.operand_a = a;
		row.item.operand_b = b;
		row.typed = 1'b1;
		row.want.result = res;
		row.want.a_less = lt;
		row.want.a_equal = eq;
		row.want.a_greater = gt;
		row.want.divide_by_zero = dz;
		directed_rows.push_back(row);
	endtask

	// valid stays high across back-to-back items; only lowered while idling
	task automatic send_item(in_item_t it, out_item_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req = it;
		do @(posedge clk); while (!req_ready);
		pending_answers.push_back(want);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_for_answers();
		while (pending_answers.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_answers.size());
			$display("FAIL fixed_point_q24_8_alu_unit");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected item", rsp.result, '0);
			end else begin
				want = pending_answers.pop_front();
				answers_checked++;
				if (want.divide_by_zero)
					zero_divides++;
				if (rsp.result !== want.result)
					report_mismatch("result", rsp.result, want.result);
				if (rsp.a_less !== want.a_less)
					report_mismatch("a_less", 32'(rsp.a_less), 32'(want.a_less));
				if (rsp.a_equal !== want.a_equal)
					report_mismatch("a_equal", 32'(rsp.a_equal), 32'(want.a_equal));
				if (rsp.a_greater !== want.a_greater)
					report_mismatch("a_greater", 32'(rsp.a_greater),
						32'(want.a_greater));
				if (rsp.divide_by_zero !== want.divide_by_zero)
					report_mismatch("divide_by_zero", 32'(rsp.divide_by_zero),
						32'(want.divide_by_zero));
			end
		end
	end

	// receiver: random stalls plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_ready = 1'b0;
				hold_left--;
			end else begin
				rsp_ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		in_item_t it;
		int ph;
		int n;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		hold_request = 1'b0;
		send_idle_pct = 31;
		recv_idle_pct = 81;
		mismatches = 0;
		answers_checked = 0;
		items_sent = 0;
		zero_divides = 0;
		cycle_count = 0;

		row_known(OP_ADD, '0, '0, '0, 0, 1, 0, 0);
		row_known(OP_ADD, MOST_POS, 32'd1, MOST_NEG, 0, 0, 1, 0);
		row_known(OP_SUB, MOST_NEG, 32'd1, MOST_POS, 1, 0, 0, 0);
		row_known(OP_SUB, MOST_POS, MOST_NEG, '1, 0, 0, 1, 0);
		row_known(OP_MUL, ONE_FX, ONE_FX, ONE_FX, 0, 1, 0, 0);
		row_pred(OP_MUL, MOST_POS, MOST_POS);
		row_pred(OP_MUL, MOST_NEG, MOST_NEG);
		row_pred(OP_MUL, MOST_NEG, MOST_POS);
		row_pred(OP_MUL, -ONE_FX, 32'h80);
		row_known(OP_DIV, ONE_FX, '0, '0, 0, 0, 1, 1);
		row_known(OP_DIV, '0, '0, '0, 0, 1, 0, 1);
		row_known(OP_DIV, MOST_NEG, '0, '0, 1, 0, 0, 1);
		row_pred(OP_DIV, MOST_NEG, '1);
		row_pred(OP_DIV, MOST_POS, 32'd1);
		row_pred(OP_DIV, 32'hffff_fd00, 32'h200);
		row_pred(OP_DIV, '1, ONE_FX);
		row_pred(OP_DIV, 32'd1, MOST_POS);
		row_pred(OP_DIV, MOST_NEG, MOST_NEG);
		row_known(OP_MIN, MOST_NEG, MOST_POS, MOST_NEG, 1, 0, 0, 0);
		row_known(OP_MAX, MOST_NEG, MOST_POS, MOST_POS, 1, 0, 0, 0);
		row_known(OP_MIN, 32'd5, 32'd5, 32'd5, 0, 1, 0, 0);
		row_known(OP_MAX, '1, '1, '1, 0, 1, 0, 0);
		row_known(OP_SPARE6, MOST_POS, MOST_NEG, '0, 0, 0, 1, 0);
		row_known(OP_SPARE7, '1, '1, '0, 0, 1, 0, 0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].item, directed_rows[i].typed ?
				directed_rows[i].want : alu_answer(directed_rows[i].item));

		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin send_idle_pct = 31; recv_idle_pct = 81; end
				1: begin send_idle_pct = 81; recv_idle_pct = 31; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				it = random_item();
				send_item(it, alu_answer(it));
				if (ph == 0 && n == 150)
					hold_request = 1'b1;
			end
			req_valid = 1'b0;
			wait_for_answers();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d items (%0d from the directed table), checked %0d results",
			items_sent, directed_rows.size(), answers_checked);
		$display("%0d divide-by-zero results, %0d mismatches", zero_divides, mismatches);
		if (mismatches == 0)
			$display("PASS fixed_point_q24_8_alu_unit");
		else
			$display("FAIL fixed_point_q24_8_alu_unit");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/fpalu_pkg.sv
hdl/fpalu_front.sv
hdl/fpalu_cell.sv
hdl/fpalu_back.sv
hdl/fixed_point_q24_8_alu_unit.sv
tb/tb_fixed_point_q24_8_alu_unit.sv
